FILE: rtl/core/rpdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rpdc_pkg
// Shared types, widths and constants of the RC pulse to drive command unit.
// ============================================================================
package rpdc_pkg;

    // Field widths
    localparam int PULSE_W   = 16;  // measured pulse widths
    localparam int REG12_W   = 12;  // pulse register width
    localparam int REG8_W    = 8;   // deadband register width
    localparam int OUT_W     = 8;   // command output width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = REG12_W;

    // Internal arithmetic widths
    localparam int CALC_W     = 18;            // signed window math
    localparam int DEN_W      = 13;            // span / offset, max 4605
    localparam int NUM_W      = DEN_W + OUT_W; // offset * output span
    localparam int Q_W        = OUT_W;         // quotient never exceeds output span
    localparam int BITS_PER_DS = 2;
    localparam int DIV_STAGES = Q_W / BITS_PER_DS;
    // front, multiply, divide stages, output register
    localparam int NUM_STAGES = DIV_STAGES + 3;

    // Default output ranges
    localparam int unsigned STEER_OUT_MIN_DEF = 0;
    localparam int unsigned STEER_OUT_MAX_DEF = 180;
    localparam int unsigned SPEED_OUT_MIN_DEF = 0;
    localparam int unsigned SPEED_OUT_MAX_DEF = 255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_STEER_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_STEER_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_STEER_DB    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_THR_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_THR_NEUTRAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_THR_MAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_THR_DB      = 3'd6;

    // Register reset values
    localparam logic [REG12_W-1:0] RST_STEER_MIN   = 12'd1000;
    localparam logic [REG12_W-1:0] RST_STEER_MAX   = 12'd2000;
    localparam logic [REG8_W-1:0]  RST_STEER_DB    = 8'd20;
    localparam logic [REG12_W-1:0] RST_THR_MIN     = 12'd1000;
    localparam logic [REG12_W-1:0] RST_THR_NEUTRAL = 12'd1500;
    localparam logic [REG12_W-1:0] RST_THR_MAX     = 12'd2000;
    localparam logic [REG8_W-1:0]  RST_THR_DB      = 8'd20;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_NEUTRAL = 2'd1,
        ACT_FORWARD = 2'd2,
        ACT_REVERSE = 2'd3
    } thr_action_t;

    typedef struct packed {
        logic [REG12_W-1:0] steer_min;
        logic [REG12_W-1:0] steer_max;
        logic [REG8_W-1:0]  steer_db;
        logic [REG12_W-1:0] thr_min;
        logic [REG12_W-1:0] thr_neutral;
        logic [REG12_W-1:0] thr_max;
        logic [REG8_W-1:0]  thr_db;
    } cfg_t;

    // Per-item flags that ride alongside the divider lanes
    typedef struct packed {
        logic        steer_in_win;
        logic        steer_zero;   // zero steering span
        thr_action_t action;
        logic        thr_zero;     // zero throttle span
    } side_t;

endpackage
`default_nettype wire

FILE: rtl/core/rpdc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rpdc_cfg_regs
// Configuration register file, plain write port, no read-back.
// ============================================================================
module rpdc_cfg_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [rpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpdc_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output rpdc_pkg::cfg_t                       cfg
);
    import rpdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                IDX_STEER_MIN:   cfg_next.steer_min   = cfg_wdata;
                IDX_STEER_MAX:   cfg_next.steer_max   = cfg_wdata;
                IDX_STEER_DB:    cfg_next.steer_db    = cfg_wdata[REG8_W-1:0];
                IDX_THR_MIN:     cfg_next.thr_min     = cfg_wdata;
                IDX_THR_NEUTRAL: cfg_next.thr_neutral = cfg_wdata;
                IDX_THR_MAX:     cfg_next.thr_max     = cfg_wdata;
                IDX_THR_DB:      cfg_next.thr_db      = cfg_wdata[REG8_W-1:0];
                default:         cfg_next = cfg_reg;  // unused index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_min   <= RST_STEER_MIN;
            cfg_reg.steer_max   <= RST_STEER_MAX;
            cfg_reg.steer_db    <= RST_STEER_DB;
            cfg_reg.thr_min     <= RST_THR_MIN;
            cfg_reg.thr_neutral <= RST_THR_NEUTRAL;
            cfg_reg.thr_max     <= RST_THR_MAX;
            cfg_reg.thr_db      <= RST_THR_DB;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rpdc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rpdc_front
// Window classification stage: bounds, band decisions, offset and span.
// ============================================================================
module rpdc_front
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [rpdc_pkg::PULSE_W-1:0]  steer_pulse,
    input  wire logic [rpdc_pkg::PULSE_W-1:0]  thr_pulse,
    input  wire rpdc_pkg::cfg_t                cfg,
    output logic      [rpdc_pkg::DEN_W-1:0]    steer_ofs,
    output logic      [rpdc_pkg::DEN_W-1:0]    steer_span,
    output logic      [rpdc_pkg::DEN_W-1:0]    thr_ofs,
    output logic      [rpdc_pkg::DEN_W-1:0]    thr_span,
    output rpdc_pkg::side_t                    side
);
    import rpdc_pkg::*;

    typedef logic signed [CALC_W-1:0] calc_t;

    calc_t s, t, slo, shi, nlo, nhi, tmax, tmin;
    calc_t s_ofs_w, s_span_w, t_ofs_w, t_span_w;
    logic  s_in;
    side_t side_next;

    logic [DEN_W-1:0] steer_ofs_reg, steer_span_reg, thr_ofs_reg, thr_span_reg;
    side_t            side_reg;

    always_comb
    begin
        s    = signed'(CALC_W'(steer_pulse));
        t    = signed'(CALC_W'(thr_pulse));
        slo  = signed'(CALC_W'(cfg.steer_min)) - signed'(CALC_W'(cfg.steer_db));
        shi  = signed'(CALC_W'(cfg.steer_max)) + signed'(CALC_W'(cfg.steer_db));
        nlo  = signed'(CALC_W'(cfg.thr_neutral)) - signed'(CALC_W'(cfg.thr_db));
        nhi  = signed'(CALC_W'(cfg.thr_neutral)) + signed'(CALC_W'(cfg.thr_db));
        tmax = signed'(CALC_W'(cfg.thr_max)) + signed'(CALC_W'(cfg.thr_db));
        tmin = signed'(CALC_W'(cfg.thr_min)) - signed'(CALC_W'(cfg.thr_db));

        s_in     = (s >= slo) && (s <= shi);
        s_ofs_w  = s - slo;
        s_span_w = shi - slo;

        // forward and reverse both reduce to offset <= span, both non-negative
        t_ofs_w  = '0;
        t_span_w = '0;
        side_next.action = ACT_NONE;
        priority if ((t >= nlo) && (t <= nhi))
        begin
            side_next.action = ACT_NEUTRAL;
        end
        else if ((t > nhi) && (t <= tmax))
        begin
            side_next.action = ACT_FORWARD;
            t_ofs_w  = t - nhi - calc_t'(1);
            t_span_w = tmax - nhi - calc_t'(1);
        end
        else if ((t >= tmin) && (t < nlo))
        begin
            side_next.action = ACT_REVERSE;
            t_ofs_w  = nlo - calc_t'(1) - t;
            t_span_w = nlo - calc_t'(1) - tmin;
        end
        else
        begin
            // outside every throttle window
            side_next.action = ACT_NONE;
        end

        side_next.steer_in_win = s_in;
        side_next.steer_zero   = (s_span_w == '0);
        side_next.thr_zero     = (t_span_w == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // outside the window the lane result is discarded later
            steer_ofs_reg  <= s_in ? s_ofs_w[DEN_W-1:0] : '0;
            steer_span_reg <= s_in ? s_span_w[DEN_W-1:0] : '0;
            thr_ofs_reg    <= t_ofs_w[DEN_W-1:0];
            thr_span_reg   <= t_span_w[DEN_W-1:0];
            side_reg       <= side_next;
        end
    end

    assign steer_ofs  = steer_ofs_reg;
    assign steer_span = steer_span_reg;
    assign thr_ofs    = thr_ofs_reg;
    assign thr_span   = thr_span_reg;
    assign side       = side_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rpdc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rpdc_divider
// Scale offset by a constant, then pipelined restoring divide by span,
// two quotient bits per stage. Requires offset <= span.
// ============================================================================
module rpdc_divider
#(
    parameter int unsigned MUL = 255
)
(
    input  wire logic                              clk,
    input  wire logic [rpdc_pkg::DIV_STAGES:0]     en,   // [0] multiply, then divide
    input  wire logic [rpdc_pkg::DEN_W-1:0]        ofs,
    input  wire logic [rpdc_pkg::DEN_W-1:0]        span,
    output logic      [rpdc_pkg::Q_W-1:0]          quot
);
    import rpdc_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_m_reg;

    logic [NUM_W-1:0] rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic [Q_W-1:0]   q_reg   [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_reg   <= NUM_W'(ofs) * NUM_W'(MUL);
            den_m_reg <= span;
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int SH_HI = Q_W - 1 - BITS_PER_DS * j;
        localparam int SH_LO = SH_HI - 1;

        logic [NUM_W-1:0] rem_in, rem_mid, rem_out, sub_hi, sub_lo;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in, q_out;
        logic             bit_hi, bit_lo;

        if (j == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign den_in = den_m_reg;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        always_comb
        begin
            sub_hi  = NUM_W'(den_in) << SH_HI;
            sub_lo  = NUM_W'(den_in) << SH_LO;
            bit_hi  = (rem_in >= sub_hi);
            rem_mid = bit_hi ? (rem_in - sub_hi) : rem_in;
            bit_lo  = (rem_mid >= sub_lo);
            rem_out = bit_lo ? (rem_mid - sub_lo) : rem_mid;
            q_out   = q_in | (Q_W'(bit_hi) << SH_HI) | (Q_W'(bit_lo) << SH_LO);
        end

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                rem_reg[j] <= rem_out;
                den_reg[j] <= den_in;
                q_reg[j]   <= q_out;
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/core/rc_pulse_to_drive_command_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rc_pulse_to_drive_command_unit
// Decodes a steering/throttle pulse-width pair into drive commands.
// ============================================================================
// Usage:
//   s_* channel: one transfer carries one measured pulse pair (microseconds).
//   m_* channel: one transfer carries the matching drive command.
//   cfg_*: write-only register port; write while no item is in flight.
// Pipeline: 7 register stages (classify, scale, four divide stages of two
//   quotient bits each, output).
// Throughput: one item per cycle while the output is not stalled; set by the divider
//   pipeline, which each lane (steering, throttle) owns outright.
// Stall: each stage holds while the stage after it is full and stalled;
//   empty stages keep filling, so s_tready drops only once every stage
//   holds an item. Nothing is lost or repeated.
// Reset: pipeline empties, configuration registers return to their reset values.
// Parameters: output ranges, 0..255 each; an inverted range still
//   interpolates, but steering is then never valid.
// ============================================================================
module rc_pulse_to_drive_command_unit
#(
    parameter int unsigned STEER_OUT_MIN = rpdc_pkg::STEER_OUT_MIN_DEF,
    parameter int unsigned STEER_OUT_MAX = rpdc_pkg::STEER_OUT_MAX_DEF,
    parameter int unsigned SPEED_OUT_MIN = rpdc_pkg::SPEED_OUT_MIN_DEF,
    parameter int unsigned SPEED_OUT_MAX = rpdc_pkg::SPEED_OUT_MAX_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,  // steer_pulse_us, thr_pulse_us
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [23:0]                     m_tdata,  // steer_valid, steer_value,
                                                           // thr_action, thr_speed, zero pad
    // configuration
    input  wire logic                            cfg_wen,
    input  wire logic [rpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rpdc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import rpdc_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // Output span magnitude and direction, fixed at elaboration
    localparam int STEER_D   = int'(STEER_OUT_MAX) - int'(STEER_OUT_MIN);
    localparam int SPEED_D   = int'(SPEED_OUT_MAX) - int'(SPEED_OUT_MIN);
    localparam int unsigned STEER_ABS = (STEER_D < 0) ? -STEER_D : STEER_D;
    localparam int unsigned SPEED_ABS = (SPEED_D < 0) ? -SPEED_D : SPEED_D;
    localparam bit STEER_NEG = (STEER_D < 0);
    localparam bit SPEED_NEG = (SPEED_D < 0);

    localparam logic [OUT_W:0] STEER_LO = (OUT_W+1)'(STEER_OUT_MIN);
    localparam logic [OUT_W:0] STEER_HI = (OUT_W+1)'(STEER_OUT_MAX);
    localparam logic [OUT_W:0] SPEED_LO = (OUT_W+1)'(SPEED_OUT_MIN);

    cfg_t cfg;

    // ---------------- pipeline control ----------------
    logic [NUM_STAGES-1:0] valid_reg, valid_next, stage_rdy;

    always_comb
    begin
        stage_rdy[LAST] = !valid_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next[0] = stage_rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = stage_rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[LAST];

    // ---------------- configuration ----------------
    rpdc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ---------------- stage 0: classify ----------------
    logic [DEN_W-1:0] steer_ofs, steer_span, thr_ofs, thr_span;
    side_t            side0;

    rpdc_front u_front
    (
        .clk         (clk),
        .en          (stage_rdy[0]),
        .steer_pulse (s_tdata[PULSE_W-1:0]),
        .thr_pulse   (s_tdata[2*PULSE_W-1:PULSE_W]),
        .cfg         (cfg),
        .steer_ofs   (steer_ofs),
        .steer_span  (steer_span),
        .thr_ofs     (thr_ofs),
        .thr_span    (thr_span),
        .side        (side0)
    );

    // ---------------- stages 1..LAST-1: scale and divide ----------------
    logic [Q_W-1:0] steer_q, thr_q;

    rpdc_divider #(.MUL(STEER_ABS)) u_div_steer
    (
        .clk  (clk),
        .en   (stage_rdy[LAST-1:1]),
        .ofs  (steer_ofs),
        .span (steer_span),
        .quot (steer_q)
    );

    rpdc_divider #(.MUL(SPEED_ABS)) u_div_thr
    (
        .clk  (clk),
        .en   (stage_rdy[LAST-1:1]),
        .ofs  (thr_ofs),
        .span (thr_span),
        .quot (thr_q)
    );

    // flags travel beside the lanes
    side_t side_reg [1:LAST-1];

    always_ff @(posedge clk)
    begin
        if (stage_rdy[1])
        begin
            side_reg[1] <= side0;
        end
        for (int k = 2; k < LAST; k++)
        begin
            if (stage_rdy[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- last stage: apply sign, offset, validity ----------------
    side_t          side_l;
    logic [Q_W-1:0] sq_eff, tq_eff;
    logic [OUT_W:0] steer_m, speed_m;
    logic           steer_ok;
    logic [23:0]    tdata_next, tdata_reg;

    always_comb
    begin
        side_l  = side_reg[LAST-1];
        // zero span maps to the low bound
        sq_eff  = side_l.steer_zero ? '0 : steer_q;
        tq_eff  = side_l.thr_zero ? '0 : thr_q;
        steer_m = STEER_NEG ? (STEER_LO - (OUT_W+1)'(sq_eff))
                            : (STEER_LO + (OUT_W+1)'(sq_eff));
        speed_m = SPEED_NEG ? (SPEED_LO - (OUT_W+1)'(tq_eff))
                            : (SPEED_LO + (OUT_W+1)'(tq_eff));
        steer_ok = side_l.steer_in_win && (steer_m > STEER_LO) && (steer_m < STEER_HI);

        tdata_next        = '0;
        tdata_next[0]     = steer_ok;
        tdata_next[8:1]   = steer_ok ? steer_m[OUT_W-1:0] : '0;
        tdata_next[10:9]  = side_l.action;
        tdata_next[18:11] = ((side_l.action == ACT_FORWARD) || (side_l.action == ACT_REVERSE))
                            ? speed_m[OUT_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[LAST])
        begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_tdata = tdata_reg;

endmodule
`default_nettype wire
